FILE: rtl/assert_macros.svh
// Assertion helpers for the demux RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/flvd_pkg.sv
package flvd_pkg;

   typedef enum logic [24:0] {
      PH_SIG    = 25'h0000001,
      PH_VER    = 25'h0000002,
      PH_FLAGS  = 25'h0000004,
      PH_HLEN   = 25'h0000008,
      PH_PREV   = 25'h0000010,
      PH_TAG    = 25'h0000020,
      PH_SKIP   = 25'h0000040,
      PH_A_FMT  = 25'h0000080,
      PH_A_TYPE = 25'h0000100,
      PH_A_CFG  = 25'h0000200,
      PH_A_RAW  = 25'h0000400,
      PH_V_FMT  = 25'h0000800,
      PH_V_TYPE = 25'h0001000,
      PH_V_CFG  = 25'h0002000,
      PH_V_CTS  = 25'h0004000,
      PH_SPSN   = 25'h0008000,
      PH_SPSL   = 25'h0010000,
      PH_SPSD   = 25'h0020000,
      PH_PPSN   = 25'h0040000,
      PH_PPSL   = 25'h0080000,
      PH_PPSD   = 25'h0100000,
      PH_NLEN   = 25'h0200000,
      PH_NFIRST = 25'h0400000,
      PH_NREST  = 25'h0800000,
      PH_IDLE   = 25'h1000000
   } phase_type;

   typedef enum logic [7:0] {
      SEG_STATUS = 8'h01,
      SEG_ADTS   = 8'h02,
      SEG_START1 = 8'h04,
      SEG_SPS    = 8'h08,
      SEG_START2 = 8'h10,
      SEG_PPS    = 8'h20,
      SEG_START3 = 8'h40,
      SEG_BYTE   = 8'h80
   } seg_type;

   typedef enum logic [3:0] {
      JOB_STATUS = 4'h1,
      JOB_ADTS   = 4'h2,
      JOB_NALU   = 4'h4,
      JOB_BYTE   = 4'h8
   } job_kind_type;

   localparam logic [2:0] ST_DATA      = 3'd0;
   localparam logic [2:0] ST_NOT_FLV   = 3'd1;
   localparam logic [2:0] ST_BAD_VER   = 3'd2;
   localparam logic [2:0] ST_NO_STREAM = 3'd3;
   localparam logic [2:0] ST_BAD_HLEN  = 3'd4;
   localparam logic [2:0] ST_CODEC     = 3'd5;
   localparam logic [2:0] ST_TRUNC     = 3'd6;

   localparam logic [7:0] TAG_AUDIO = 8'h08;
   localparam logic [7:0] TAG_VIDEO = 8'h09;
   localparam logic [3:0] FMT_AAC   = 4'hA;
   localparam logic [3:0] CODEC_AVC = 4'h7;
   localparam logic [4:0] NALU_IDR  = 5'h05;
   localparam logic [7:0] FLV_VER   = 8'h01;
   localparam logic [7:0] HLEN_LAST = 8'h09;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
      logic         last;
      logic         idr;
      logic [2:0]   code;
      logic         media;
      logic         stream;
      logic [31:0]  stamp;
      logic [12:0]  frame_len;
      logic [7:0]   cfg0;
      logic [7:0]   cfg1;
   } job_type;

   function automatic logic [7:0] sig_byte(input logic [3:0] idx);
      case (idx)
         4'd0:    sig_byte = 8'h46;
         4'd1:    sig_byte = 8'h4C;
         default: sig_byte = 8'h56;
      endcase
   endfunction

endpackage

FILE: rtl/flvd_emitter.sv
module flvd_emitter #(
   parameter int SPS_MAX_BYTES = 24,
   parameter int PPS_MAX_BYTES = 24,
   parameter int LEN_W = 5,
   parameter int AW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_go,
   input  flvd_pkg::job_type job,
   output logic              ready,
   input  logic [LEN_W-1:0]  sps_len,
   input  logic [LEN_W-1:0]  pps_len,
   input  logic              mem_we,
   input  logic [AW-1:0]     mem_waddr,
   input  logic [7:0]        mem_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_media_kind,
   output logic              rsp_stream_number,
   output logic [31:0]       rsp_time_stamp,
   output logic              rsp_packet_end,
   output logic [2:0]        rsp_status
);
   import flvd_pkg::*;

   localparam int DEPTH = SPS_MAX_BYTES + PPS_MAX_BYTES;

   logic [7:0] mem [DEPTH];
   logic [7:0] mem_q_ff;
   logic [AW-1:0] rd_addr;

   logic active_ff, active_in;
   seg_type seg_ff, seg_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   job_type job_ff, job_in;

   logic valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic kind_ff, kind_in, strm_ff, strm_in, end_ff, end_in;
   logic [31:0] ts_ff, ts_in;
   logic [2:0] st_ff, st_in;

   logic take, is_last;
   logic [7:0] word;
   logic [7:0] adts_b2, adts_b3, adts_b4, adts_b5;
   logic [1:0] aot_m1;

   assign take  = active_ff && (!valid_ff || !rsp_stall);
   assign ready = !active_ff || (take && is_last);

   assign aot_m1  = job_ff.cfg0[4:3] - 2'd1;
   assign adts_b2 = {aot_m1, job_ff.cfg0[2:0], job_ff.cfg1[7], 1'b0, job_ff.cfg1[5]};
   assign adts_b3 = {job_ff.cfg1[4:3], 4'h0, job_ff.frame_len[12:11]};
   assign adts_b4 = job_ff.frame_len[10:3];
   assign adts_b5 = {job_ff.frame_len[2:0], 5'h1F};

   always_comb begin
      word    = 8'h00;
      is_last = 1'b0;
      end_in  = 1'b0;
      seg_in  = seg_ff;
      idx_in  = idx_ff;
      case (seg_ff)
         SEG_STATUS: begin
            is_last = 1'b1;
         end
         SEG_ADTS: begin
            case (idx_ff[2:0])
               3'd0:    word = 8'hFF;
               3'd1:    word = 8'hF1;
               3'd2:    word = adts_b2;
               3'd3:    word = adts_b3;
               3'd4:    word = adts_b4;
               3'd5:    word = adts_b5;
               default: word = 8'hFC;
            endcase
            if (idx_ff == LEN_W'(6)) begin
               is_last = 1'b1;
               end_in  = job_ff.last;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         SEG_START1, SEG_START2, SEG_START3: begin
            word = (idx_ff == LEN_W'(3)) ? 8'h01 : 8'h00;
            if (idx_ff == LEN_W'(3)) begin
               idx_in = '0;
               if (seg_ff == SEG_START1)
                  seg_in = !job_ff.idr ? SEG_BYTE : (sps_len != '0) ? SEG_SPS : SEG_START2;
               else if (seg_ff == SEG_START2)
                  seg_in = (pps_len != '0) ? SEG_PPS : SEG_START3;
               else
                  seg_in = SEG_BYTE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         SEG_SPS: begin
            word = mem_q_ff;
            if (idx_ff + 1'b1 == sps_len) begin
               seg_in = SEG_START2;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         SEG_PPS: begin
            word = mem_q_ff;
            if (idx_ff + 1'b1 == pps_len) begin
               seg_in = SEG_START3;
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         SEG_BYTE: begin
            word    = job_ff.data;
            is_last = 1'b1;
            end_in  = job_ff.last;
         end
         default: begin
            is_last = 1'b1;
         end
      endcase

      active_in = active_ff;
      job_in    = job_ff;
      if (!take) begin
         seg_in = seg_ff;
         idx_in = idx_ff;
      end
      if (job_go) begin
         active_in = 1'b1;
         job_in    = job;
         idx_in    = '0;
         case (job.kind)
            JOB_STATUS: seg_in = SEG_STATUS;
            JOB_ADTS:   seg_in = SEG_ADTS;
            JOB_NALU:   seg_in = SEG_START1;
            default:    seg_in = SEG_BYTE;
         endcase
      end else if (take && is_last) begin
         active_in = 1'b0;
      end

      if (seg_in == SEG_PPS)
         rd_addr = AW'(SPS_MAX_BYTES) + AW'(idx_in);
      else
         rd_addr = AW'(idx_in);

      byte_in = byte_ff;
      kind_in = kind_ff;
      strm_in = strm_ff;
      ts_in   = ts_ff;
      st_in   = st_ff;
      if (take) begin
         if (seg_ff == SEG_STATUS) begin
            byte_in = 8'h00;
            kind_in = 1'b0;
            strm_in = 1'b0;
            ts_in   = '0;
            st_in   = job_ff.code;
         end else begin
            byte_in = word;
            kind_in = job_ff.media;
            strm_in = job_ff.stream;
            ts_in   = job_ff.stamp;
            st_in   = ST_DATA;
         end
      end else begin
         end_in = end_ff;
      end
      if (!valid_ff || !rsp_stall)
         valid_in = take;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         seg_ff    <= SEG_STATUS;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         seg_ff    <= seg_in;
         idx_ff    <= idx_in;
      end
      job_ff  <= job_in;
      byte_ff <= byte_in;
      kind_ff <= kind_in;
      strm_ff <= strm_in;
      ts_ff   <= ts_in;
      st_ff   <= st_in;
      end_ff  <= end_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_media_kind    = kind_ff;
   assign rsp_stream_number = strm_ff;
   assign rsp_time_stamp    = ts_ff;
   assign rsp_packet_end    = end_ff;
   assign rsp_status        = st_ff;

endmodule

FILE: rtl/flv_to_elementary_stream_demux.sv
// An accepted word loads the emitter's job register; each result word is then
// loaded into the output register. Throughput: one input word per cycle when
// it yields no result and no results are pending; otherwise the input stalls
// until its last result word is loaded (up to 61 for an IDR with both sets).
// Reset: synchronous, clears parser and output control; set store needs none.
`include "assert_macros.svh"

module flv_to_elementary_stream_demux #(
   parameter int SPS_MAX_BYTES = 24,
   parameter int PPS_MAX_BYTES = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   input  logic        req_file_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_media_kind,
   output logic        rsp_stream_number,
   output logic [31:0] rsp_time_stamp,
   output logic        rsp_packet_end,
   output logic [2:0]  rsp_status
);
   import flvd_pkg::*;

   localparam int MAXB  = (SPS_MAX_BYTES > PPS_MAX_BYTES) ? SPS_MAX_BYTES : PPS_MAX_BYTES;
   localparam int LEN_W = $clog2(MAXB + 1);
   localparam int AW    = $clog2(SPS_MAX_BYTES + PPS_MAX_BYTES);

   phase_type phase_ff, phase_in;
   logic [3:0]  fcnt_ff, fcnt_in;
   logic [7:0]  tkind_ff, tkind_in;
   logic [23:0] tleft_ff, tleft_in;
   logic [31:0] ttime_ff, ttime_in;
   logic [31:0] nleft_ff, nleft_in;
   logic [7:0]  acfg0_ff, acfg0_in, acfg1_ff, acfg1_in;
   logic [LEN_W-1:0] spsl_ff, spsl_in, ppsl_ff, ppsl_in;
   logic [7:0]  scnt_ff, scnt_in;
   logic [15:0] sleft_ff, sleft_in;
   logic [1:0]  flags_ff, flags_in;
   logic        err_ff, err_in;

   logic        accept, ready, body, tail, failed;
   logic        job_go;
   job_type     job;
   logic        mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]  b;
   logic [23:0] tl_dec;

   assign accept    = req_valid && ready;
   assign req_stall = !ready;
   assign b         = req_data_byte;

   always_comb begin
      phase_in = phase_ff;  fcnt_in  = fcnt_ff;  tkind_in = tkind_ff;
      tleft_in = tleft_ff;  ttime_in = ttime_ff; nleft_in = nleft_ff;
      acfg0_in = acfg0_ff;  acfg1_in = acfg1_ff; spsl_in  = spsl_ff;
      ppsl_in  = ppsl_ff;   scnt_in  = scnt_ff;  sleft_in = sleft_ff;
      flags_in = flags_ff;  err_in   = err_ff;
      job_go    = 1'b0;
      job       = '0;
      job.kind  = JOB_STATUS;
      mem_we    = 1'b0;
      mem_waddr = '0;
      failed    = 1'b0;
      body      = 1'b0;
      tail      = 1'b0;
      tl_dec    = '0;
      if (accept) begin
         if (req_file_start) begin
            phase_in = PH_SIG; fcnt_in = '0; tkind_in = '0; tleft_in = '0;
            ttime_in = '0; nleft_in = '0; acfg0_in = '0; acfg1_in = '0;
            spsl_in = '0; ppsl_in = '0; scnt_in = '0; sleft_in = '0;
            flags_in = '0; err_in = 1'b0;
         end
         if (!err_in && phase_in != PH_IDLE) begin
            body = !(phase_in inside {PH_SIG, PH_VER, PH_FLAGS, PH_HLEN, PH_PREV, PH_TAG});
            if (body) begin
               tl_dec   = tleft_in - 1'b1;
               tleft_in = tl_dec;
               tail     = (tl_dec == '0);
            end
            job.stamp = ttime_in;
            case (phase_in)
               PH_SIG: begin
                  if (b != sig_byte(fcnt_in)) begin
                     failed = 1'b1; job.code = ST_NOT_FLV;
                  end else if (fcnt_in == 4'd2) begin
                     phase_in = PH_VER; fcnt_in = '0;
                  end else begin
                     fcnt_in = fcnt_in + 1'b1;
                  end
               end
               PH_VER: begin
                  if (b != FLV_VER) begin
                     failed = 1'b1; job.code = ST_BAD_VER;
                  end else begin
                     phase_in = PH_FLAGS;
                  end
               end
               PH_FLAGS: begin
                  flags_in = {b[2], b[0]};
                  if (flags_in == 2'b00) begin
                     failed = 1'b1; job.code = ST_NO_STREAM;
                  end else begin
                     phase_in = PH_HLEN; fcnt_in = '0;
                  end
               end
               PH_HLEN: begin
                  if (b != ((fcnt_in == 4'd3) ? HLEN_LAST : 8'h00)) begin
                     failed = 1'b1; job.code = ST_BAD_HLEN;
                  end else if (fcnt_in == 4'd3) begin
                     phase_in = PH_PREV; fcnt_in = '0;
                  end else begin
                     fcnt_in = fcnt_in + 1'b1;
                  end
               end
               PH_PREV: begin
                  if (fcnt_in == 4'd3) begin
                     phase_in = PH_TAG; fcnt_in = '0;
                  end else begin
                     fcnt_in = fcnt_in + 1'b1;
                  end
               end
               PH_TAG: begin
                  case (fcnt_in)
                     4'd0:             tkind_in = b;
                     4'd1, 4'd2, 4'd3: tleft_in = {tleft_in[15:0], b};
                     4'd4:             ttime_in = {24'h0, b};
                     4'd5, 4'd6:       ttime_in = {8'h0, ttime_in[15:0], b};
                     4'd7:             ttime_in[31:24] = b;
                     default:          ;
                  endcase
                  if (fcnt_in < 4'd10) begin
                     fcnt_in = fcnt_in + 1'b1;
                  end else begin
                     fcnt_in = '0;
                     if (tleft_in == '0)          phase_in = PH_PREV;
                     else if (tkind_in == TAG_AUDIO) phase_in = PH_A_FMT;
                     else if (tkind_in == TAG_VIDEO) phase_in = PH_V_FMT;
                     else                          phase_in = PH_SKIP;
                  end
               end
               PH_A_FMT: begin
                  if (b[7:4] != FMT_AAC) begin
                     failed = 1'b1; job.code = ST_CODEC;
                  end else begin
                     phase_in = PH_A_TYPE;
                  end
               end
               PH_A_TYPE: begin
                  if (b == 8'h00) begin
                     phase_in = PH_A_CFG; fcnt_in = '0;
                  end else if (b == 8'h01) begin
                     job_go        = 1'b1;
                     job.kind      = JOB_ADTS;
                     job.frame_len = tl_dec[12:0] + 13'd7;
                     job.cfg0      = acfg0_in;
                     job.cfg1      = acfg1_in;
                     job.last      = tail;
                     job.media     = 1'b1;
                     job.stream    = flags_in[0];
                     phase_in      = PH_A_RAW;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_A_CFG: begin
                  if (fcnt_in == '0) acfg0_in = b;
                  else               acfg1_in = b;
                  if (fcnt_in != '0) phase_in = PH_SKIP;
                  fcnt_in = fcnt_in + 1'b1;
               end
               PH_A_RAW: begin
                  job_go     = 1'b1;
                  job.kind   = JOB_BYTE;
                  job.data   = b;
                  job.last   = tail;
                  job.media  = 1'b1;
                  job.stream = flags_in[0];
               end
               PH_V_FMT: begin
                  if (b[3:0] != CODEC_AVC) begin
                     failed = 1'b1; job.code = ST_CODEC;
                  end else begin
                     phase_in = PH_V_TYPE;
                  end
               end
               PH_V_TYPE: begin
                  fcnt_in  = '0;
                  phase_in = (b == 8'h00) ? PH_V_CFG : (b == 8'h01) ? PH_V_CTS : PH_SKIP;
               end
               PH_V_CFG: begin
                  fcnt_in = fcnt_in + 1'b1;
                  if (fcnt_in >= 4'd8) phase_in = PH_SPSN;
               end
               PH_SPSN: begin
                  scnt_in  = {3'b000, b[4:0]};
                  fcnt_in  = '0;
                  phase_in = (scnt_in != '0) ? PH_SPSL : PH_PPSN;
               end
               PH_PPSN: begin
                  scnt_in  = b;
                  fcnt_in  = '0;
                  phase_in = (scnt_in != '0) ? PH_PPSL : PH_SKIP;
               end
               PH_SPSL, PH_PPSL: begin
                  if (fcnt_in == '0) begin
                     sleft_in = {8'h00, b};
                     fcnt_in  = 4'd1;
                  end else begin
                     sleft_in = {sleft_in[7:0], b};
                     if (phase_in == PH_SPSL) begin
                        spsl_in = '0;
                        if (sleft_in > 16'(SPS_MAX_BYTES)) begin
                           job_go = 1'b1; job.code = ST_TRUNC; job.stamp = '0;
                        end
                        if (sleft_in == '0) begin
                           scnt_in  = scnt_in - 1'b1; fcnt_in = '0;
                           phase_in = (scnt_in != '0) ? PH_SPSL : PH_PPSN;
                        end else begin
                           phase_in = PH_SPSD;
                        end
                     end else begin
                        ppsl_in = '0;
                        if (sleft_in > 16'(PPS_MAX_BYTES)) begin
                           job_go = 1'b1; job.code = ST_TRUNC; job.stamp = '0;
                        end
                        if (sleft_in == '0) begin
                           scnt_in  = scnt_in - 1'b1; fcnt_in = '0;
                           phase_in = (scnt_in != '0) ? PH_PPSL : PH_SKIP;
                        end else begin
                           phase_in = PH_PPSD;
                        end
                     end
                  end
               end
               PH_SPSD: begin
                  if (spsl_in < LEN_W'(SPS_MAX_BYTES)) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(spsl_in);
                     spsl_in   = spsl_in + 1'b1;
                  end
                  sleft_in = sleft_in - 1'b1;
                  if (sleft_in == '0) begin
                     scnt_in  = scnt_in - 1'b1; fcnt_in = '0;
                     phase_in = (scnt_in != '0) ? PH_SPSL : PH_PPSN;
                  end
               end
               PH_PPSD: begin
                  if (ppsl_in < LEN_W'(PPS_MAX_BYTES)) begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(SPS_MAX_BYTES) + AW'(ppsl_in);
                     ppsl_in   = ppsl_in + 1'b1;
                  end
                  sleft_in = sleft_in - 1'b1;
                  if (sleft_in == '0) begin
                     scnt_in  = scnt_in - 1'b1; fcnt_in = '0;
                     phase_in = (scnt_in != '0) ? PH_PPSL : PH_SKIP;
                  end
               end
               PH_V_CTS: begin
                  fcnt_in = fcnt_in + 1'b1;
                  if (fcnt_in >= 4'd3) begin
                     phase_in = PH_NLEN; fcnt_in = '0;
                  end
               end
               PH_NLEN: begin
                  nleft_in = (fcnt_in == '0) ? {24'h0, b} : {nleft_in[23:0], b};
                  fcnt_in  = fcnt_in + 1'b1;
                  if (fcnt_in >= 4'd4) begin
                     fcnt_in = '0;
                     if (nleft_in != '0) phase_in = PH_NFIRST;
                  end
               end
               PH_NFIRST, PH_NREST: begin
                  nleft_in = nleft_in - 1'b1;
                  job_go   = 1'b1;
                  job.kind = (phase_in == PH_NFIRST) ? JOB_NALU : JOB_BYTE;
                  job.idr  = (phase_in == PH_NFIRST) && (b[4:0] == NALU_IDR);
                  job.data = b;
                  job.last = tail || (nleft_in == '0);
                  fcnt_in  = '0;
                  phase_in = (nleft_in == '0) ? PH_NLEN : PH_NREST;
               end
               default: ;
            endcase
            if (failed) begin
               err_in    = 1'b1;
               phase_in  = PH_IDLE;
               job_go    = 1'b1;
               job.kind  = JOB_STATUS;
               job.stamp = '0;
            end else if (body && tail) begin
               phase_in = PH_PREV;
               fcnt_in  = '0;
            end
         end
         if (req_file_last)
            phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIG;  fcnt_ff  <= '0; tkind_ff <= '0; tleft_ff <= '0;
         ttime_ff <= '0;      nleft_ff <= '0; acfg0_ff <= '0; acfg1_ff <= '0;
         spsl_ff  <= '0;      ppsl_ff  <= '0; scnt_ff  <= '0; sleft_ff <= '0;
         flags_ff <= '0;      err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in; fcnt_ff  <= fcnt_in;  tkind_ff <= tkind_in;
         tleft_ff <= tleft_in; ttime_ff <= ttime_in; nleft_ff <= nleft_in;
         acfg0_ff <= acfg0_in; acfg1_ff <= acfg1_in; spsl_ff  <= spsl_in;
         ppsl_ff  <= ppsl_in;  scnt_ff  <= scnt_in;  sleft_ff <= sleft_in;
         flags_ff <= flags_in; err_ff   <= err_in;
      end
   end

   flvd_emitter #(
      .SPS_MAX_BYTES(SPS_MAX_BYTES),
      .PPS_MAX_BYTES(PPS_MAX_BYTES),
      .LEN_W(LEN_W),
      .AW(AW)
   ) u_emitter (
      .clock(clock),
      .reset(reset),
      .job_go(job_go),
      .job(job),
      .ready(ready),
      .sps_len(spsl_ff),
      .pps_len(ppsl_ff),
      .mem_we(mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_media_kind(rsp_media_kind),
      .rsp_stream_number(rsp_stream_number),
      .rsp_time_stamp(rsp_time_stamp),
      .rsp_packet_end(rsp_packet_end),
      .rsp_status(rsp_status)
   );

   `ASSERT_IMPL(a_status_word_clean, clock, reset, rsp_valid && rsp_status != ST_DATA, rsp_out_byte == 8'h00 && !rsp_packet_end && rsp_time_stamp == '0, "status word carries data")
   `ASSERT_NEXT(a_last_idles, clock, reset, req_valid && !req_stall && req_file_last, phase_ff == PH_IDLE, "parser not idle after last word")
   `ASSERT_IMPL(a_error_idles, clock, reset, err_ff, phase_ff == PH_IDLE, "latched error without idle parser")

endmodule
